[design/zx_screen_image_writer_top_assert.svh]
// Assertion macros shared by the screen writer modules.
`ifndef ZX_SCREEN_IMAGE_WRITER_TOP_ASSERT_SVH
`define ZX_SCREEN_IMAGE_WRITER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define ZXSIW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define ZXSIW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZXSIW_ASSERT(label, clk, rst, prop, msg)
`define ZXSIW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[design/zxsiw_pkg.sv]
package zxsiw_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned COL_W    = 5;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned WIDTH_W  = 6;
  localparam int unsigned HEIGHT_W = 5;
  localparam int unsigned CCOL_W   = 6;
  localparam int unsigned LINE_W   = 8;
  localparam int unsigned AROW_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [ADDR_W-1:0] DEF_SCREEN_BASE = 16'd16384;
  localparam logic [ADDR_W-1:0] DEF_ATTR_BASE   = 16'd22528;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_COLUMN = 2'd0,
    REG_START_ROW    = 2'd1,
    REG_WIDTH_BYTES  = 2'd2,
    REG_HEIGHT_CHARS = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [COL_W-1:0]    start_column;
    logic [ROW_W-1:0]    start_row;
    logic [WIDTH_W-1:0]  width_bytes;
    logic [HEIGHT_W-1:0] height_chars;
  } cfg_t;

  // One byte with the position it lands on.
  typedef struct packed {
    logic                is_attr;
    logic [CCOL_W-1:0]   column;
    logic [LINE_W-1:0]   line;
    logic [AROW_W-1:0]   attr_row;
    logic [DATA_W-1:0]   data;
  } item_t;

endpackage

[design/zxsiw_if.sv]
interface zxsiw_in_if;
  logic                          valid;
  logic                          ready;
  logic [zxsiw_pkg::DATA_W-1:0]  data_byte;
  logic                          first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface zxsiw_out_if;
  logic                          valid;
  logic                          ready;
  logic [zxsiw_pkg::ADDR_W-1:0]  write_address;
  logic [zxsiw_pkg::DATA_W-1:0]  write_data;
  logic                          is_attribute;

  modport source (output valid, output write_address, output write_data,
                  output is_attribute, input ready);
  modport sink   (input valid, input write_address, input write_data,
                  input is_attribute, output ready);
endinterface

interface zxsiw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [zxsiw_pkg::CFG_IDX_W-1:0]  index;
  logic [zxsiw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/zxsiw_cfg.sv]
module zxsiw_cfg (
  input  logic               clk,
  input  logic               rst,
  zxsiw_cfg_if.sink          cfg,
  output zxsiw_pkg::cfg_t    regs
);

  zxsiw_pkg::reg_index_t idx;

  assign cfg.ready = 1'b1;
  assign idx = zxsiw_pkg::reg_index_t'(cfg.index);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_column <= '0;
      regs.start_row    <= '0;
      regs.width_bytes  <= zxsiw_pkg::WIDTH_W'(1);
      regs.height_chars <= zxsiw_pkg::HEIGHT_W'(1);
    end else if (cfg.valid) begin
      case (idx)
        zxsiw_pkg::REG_START_COLUMN:
          regs.start_column <= cfg.data[zxsiw_pkg::COL_W-1:0];
        zxsiw_pkg::REG_START_ROW:
          regs.start_row <= cfg.data[zxsiw_pkg::ROW_W-1:0];
        zxsiw_pkg::REG_WIDTH_BYTES:
          regs.width_bytes <= cfg.data[zxsiw_pkg::WIDTH_W-1:0];
        zxsiw_pkg::REG_HEIGHT_CHARS:
          regs.height_chars <= cfg.data[zxsiw_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/zxsiw_cursor.sv]
`include "zx_screen_image_writer_top_assert.svh"

// Tracks column/line/attribute row of the image and registers each byte
// together with the position it is written to.
module zxsiw_cursor (
  input  logic                  clk,
  input  logic                  rst,
  zxsiw_in_if.sink              byte_in,
  input  zxsiw_pkg::cfg_t       regs,
  output logic                  item_valid,
  input  logic                  item_ready,
  output zxsiw_pkg::item_t      item
);

  logic                          phase, phase_next;
  logic [zxsiw_pkg::CCOL_W-1:0]  column, column_next;
  logic [zxsiw_pkg::LINE_W-1:0]  line, line_next;
  logic [zxsiw_pkg::AROW_W-1:0]  attr_row, attr_row_next;

  logic                          cur_phase;
  logic [zxsiw_pkg::CCOL_W-1:0]  cur_column;
  logic [zxsiw_pkg::LINE_W-1:0]  cur_line;
  logic [zxsiw_pkg::AROW_W-1:0]  cur_attr_row;
  logic [zxsiw_pkg::WIDTH_W-1:0] w_eff;
  logic [zxsiw_pkg::HEIGHT_W-1:0] h_eff;
  logic [zxsiw_pkg::LINE_W-1:0]  h_lines;
  logic [zxsiw_pkg::LINE_W-1:0]  line_inc;
  logic                          row_end;
  logic                          fire;

  assign byte_in.ready = !item_valid || item_ready;
  assign fire = byte_in.valid && byte_in.ready;

  always_comb begin
    // a first beat restarts the image before it is placed
    cur_phase    = byte_in.first ? 1'b0 : phase;
    cur_column   = byte_in.first ? '0 : column;
    cur_line     = byte_in.first ? '0 : line;
    cur_attr_row = byte_in.first ? '0 : attr_row;

    w_eff   = (regs.width_bytes == '0) ? zxsiw_pkg::WIDTH_W'(1) : regs.width_bytes;
    h_eff   = (regs.height_chars == '0) ? zxsiw_pkg::HEIGHT_W'(1) : regs.height_chars;
    h_lines = {h_eff, 3'b000};
    line_inc = cur_line + zxsiw_pkg::LINE_W'(1);
    row_end = ({1'b0, cur_column} + 7'd1) >= {1'b0, w_eff};

    phase_next    = cur_phase;
    column_next   = cur_column + zxsiw_pkg::CCOL_W'(1);
    line_next     = cur_line;
    attr_row_next = cur_attr_row;
    if (row_end) begin
      column_next = '0;
      if (cur_phase) begin
        attr_row_next = cur_attr_row + zxsiw_pkg::AROW_W'(1);
      end else begin
        line_next  = line_inc;
        phase_next = (line_inc >= h_lines);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 1'b0;
      column     <= '0;
      line       <= '0;
      attr_row   <= '0;
      item_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase      <= phase_next;
        column     <= column_next;
        line       <= line_next;
        attr_row   <= attr_row_next;
        item_valid <= 1'b1;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      item.is_attr  <= cur_phase;
      item.column   <= cur_column;
      item.line     <= cur_line;
      item.attr_row <= cur_attr_row;
      item.data     <= byte_in.data_byte;
    end
  end

  `ZXSIW_ASSERT(a_phase_sticky, clk, rst, (phase && !(fire && byte_in.first)) |=> phase, "attribute phase dropped without a first beat")
  `ZXSIW_ASSERT(a_attr_row_in_phase, clk, rst, (attr_row != '0) |-> phase, "attribute rows counted outside attribute phase")
  `ZXSIW_ASSERT(a_stage_hold, clk, rst, (item_valid && !item_ready) |=> (item_valid && $stable(item)), "stalled stage lost its byte")
  `ZXSIW_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !item_valid, "stage valid after reset")

endmodule

[design/zxsiw_addr.sv]
`include "zx_screen_image_writer_top_assert.svh"

// Forms the screen address of a placed byte and holds it in the result register.
module zxsiw_addr #(
  parameter logic [zxsiw_pkg::ADDR_W-1:0] SCREEN_BASE = zxsiw_pkg::DEF_SCREEN_BASE,
  parameter logic [zxsiw_pkg::ADDR_W-1:0] ATTR_BASE   = zxsiw_pkg::DEF_ATTR_BASE
) (
  input  logic              clk,
  input  logic              rst,
  input  zxsiw_pkg::cfg_t   regs,
  input  logic              item_valid,
  output logic              item_ready,
  input  zxsiw_pkg::item_t  item,
  zxsiw_out_if.source       write_out
);

  logic [8:0]                    pix_line;
  logic [8:0]                    attr_line;
  logic [zxsiw_pkg::ADDR_W-1:0]  col_sum;
  logic [zxsiw_pkg::ADDR_W-1:0]  bitmap_addr;
  logic [zxsiw_pkg::ADDR_W-1:0]  attr_addr;
  logic                          take;

  assign item_ready = !write_out.valid || write_out.ready;
  assign take = item_valid && item_ready;

  always_comb begin
    pix_line  = {1'b0, regs.start_row, 3'b000} + {1'b0, item.line};
    attr_line = {4'b0000, regs.start_row} + {1'b0, item.attr_row};
    col_sum   = zxsiw_pkg::ADDR_W'(regs.start_column) + zxsiw_pkg::ADDR_W'(item.column);
    // third of screen, pixel row within cell, then cell row within third
    bitmap_addr = SCREEN_BASE
                + {2'b00, pix_line[8:6], 11'd0}
                + {5'd0, pix_line[2:0], 8'd0}
                + {8'd0, pix_line[5:3], 5'd0}
                + col_sum;
    attr_addr = ATTR_BASE + {2'b00, attr_line, 5'd0} + col_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_out.valid <= 1'b0;
    end else if (take) begin
      write_out.valid <= 1'b1;
    end else if (write_out.ready) begin
      write_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      write_out.write_address <= item.is_attr ? attr_addr : bitmap_addr;
      write_out.write_data    <= item.data;
      write_out.is_attribute  <= item.is_attr;
    end
  end

  `ZXSIW_ASSERT(a_take_only_free, clk, rst, take |-> (!write_out.valid || write_out.ready), "result overwritten while held")
  `ZXSIW_ASSERT(a_data_through, clk, rst, take |=> (write_out.write_data == $past(item.data)), "byte changed on its way out")
  `ZXSIW_ASSERT(a_out_hold, clk, rst, (write_out.valid && !write_out.ready) |=> (write_out.valid && $stable(write_out.write_address)), "held result changed")

endmodule

[design/zx_screen_image_writer_top.sv]
// Channel     Dir  Beat contents
// byte_in     in   data_byte, first
// write_out   out  write_address, write_data, is_attribute
// cfg         in   index, data (register write)
//
// One byte per cycle sustained while write_out is ready; a byte reaches write_out
// through the position register, then the address register.
// cfg is always ready; a write takes effect on the next cycle.
// rst is synchronous: registers return to column 0, row 0, width 1, height 1.
// A stall on write_out fills the two stages, then holds byte_in off.
module zx_screen_image_writer_top #(
  parameter logic [zxsiw_pkg::ADDR_W-1:0] SCREEN_BASE = zxsiw_pkg::DEF_SCREEN_BASE,
  parameter logic [zxsiw_pkg::ADDR_W-1:0] ATTR_BASE   = zxsiw_pkg::DEF_ATTR_BASE
) (
  input  logic         clk,
  input  logic         rst,
  zxsiw_in_if.sink     byte_in,
  zxsiw_out_if.source  write_out,
  zxsiw_cfg_if.sink    cfg
);

  zxsiw_pkg::cfg_t   regs;
  zxsiw_pkg::item_t  item;
  logic              item_valid;
  logic              item_ready;

  zxsiw_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  zxsiw_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .regs       (regs),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  zxsiw_addr #(
    .SCREEN_BASE (SCREEN_BASE),
    .ATTR_BASE   (ATTR_BASE)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .write_out  (write_out)
  );

endmodule
